// ===== design/zone_color_averager_macros.svh =====
// Assertion helpers for the zone averager checker.
`ifndef ZONE_COLOR_AVERAGER_MACROS_SVH
`define ZONE_COLOR_AVERAGER_MACROS_SVH

// Assert that a trigger implies a consequence on the next cycle.
`define ZCA_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("zca check failed");

// Assert that a condition implies a consequence in the same cycle.
`define ZCA_ASSERT_NOW(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("zca check failed");

`endif

// ===== design/zca_pkg.sv =====
package zca_pkg;

   localparam int MaxZonesDefault  = 64;
   localparam int CoordBits        = 12;
   localparam int SumBits          = 20;
   localparam int CountBits        = 12;
   localparam logic [CountBits-1:0] CountMax = 12'd4095;
   localparam logic [5:0] WindowReset = 6'd19;
   localparam logic [6:0] ActiveReset = 7'd64;
   localparam int QueueDepth = 4;

   typedef enum logic [1:0] {
      CMD_SET_ZONE = 2'd0,
      CMD_PIXEL    = 2'd1,
      CMD_END      = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   localparam logic CSR_WINDOW = 1'b0;
   localparam logic CSR_ACTIVE = 1'b1;

   typedef struct packed {
      logic [1:0]           command;
      logic [5:0]           zone_index;
      logic [CoordBits-1:0] pos_x;
      logic [CoordBits-1:0] pos_y;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
   } req_type;

   typedef struct packed {
      logic [5:0] zone_id;
      logic [7:0] avg_red;
      logic [7:0] avg_green;
      logic [7:0] avg_blue;
      logic       last;
   } rsp_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== design/zca_front.sv =====
// Accepts items, drops unused commands, pushes the rest into a short queue.
module zca_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  zca_pkg::req_type req_data,
   input  logic             pop,
   output logic             q_valid,
   output zca_pkg::req_type q_data
);
   import zca_pkg::*;

   localparam int PtrBits = $clog2(QueueDepth);

   req_type             mem_ff [QueueDepth];
   logic [PtrBits-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]    cnt_ff, cnt_in;
   q_status_type        st;
   logic                take, push;

   assign st.full  = (cnt_ff == (PtrBits+1)'(QueueDepth));
   assign st.empty = (cnt_ff == '0);
   assign req_stall = st.full;
   assign take = req_valid && !st.full;
   assign push = take && (req_data.command != CMD_NONE);
   assign q_valid = !st.empty;
   assign q_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = (pop && !st.empty) ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - ((pop && !st.empty) ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req_data;
   end
endmodule

// ===== design/zca_divider.sv =====
// Restoring divider: 20-bit sum by 12-bit count, one quotient bit per cycle.
module zca_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [zca_pkg::SumBits-1:0]   dividend,
   input  logic [zca_pkg::CountBits-1:0] divisor,
   output logic                          done,
   output logic [7:0]                    quotient
);
   import zca_pkg::*;

   localparam int StepBits = $clog2(SumBits + 1);

   logic [SumBits-1:0]   quo_ff, quo_in;
   logic [CountBits:0]   rem_ff, rem_in;
   logic [CountBits-1:0] div_ff;
   logic [StepBits-1:0]  step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic [CountBits:0]   trial;

   assign done = busy_ff && (step_ff == StepBits'(1));
   assign quotient = quo_in[7:0];

   always_comb begin
      trial   = {rem_ff[CountBits-1:0], quo_ff[SumBits-1]};
      quo_in  = {quo_ff[SumBits-2:0], 1'b0};
      rem_in  = trial;
      if (trial >= {1'b0, div_ff}) begin
         rem_in    = trial - {1'b0, div_ff};
         quo_in[0] = 1'b1;
      end
      busy_in = busy_ff && !done;
      step_in = step_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= StepBits'(SumBits);
      end else if (busy_ff) begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end
endmodule

// ===== design/zca_back.sv =====
// Executes queued items: table writes, a read and a write state per zone for
// pixels, and a divide/emit/clear sweep at end of frame.
module zca_back #(
   parameter int MAX_ZONES  = zca_pkg::MaxZonesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  zca_pkg::req_type q_data,
   output logic             pop,
   input  logic [5:0]       window_size,
   input  logic [6:0]       active_zones,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output zca_pkg::rsp_type rsp_data
);
   import zca_pkg::*;

   localparam int ZB = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int CB = CoordBits;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_PIX_RD, ST_PIX_WR, ST_END_RD, ST_DIV_R, ST_DIV_G,
      ST_DIV_B, ST_EMIT, ST_WAIT
   } state_type;

   typedef struct packed {
      logic [SumBits-1:0]   r;
      logic [SumBits-1:0]   g;
      logic [SumBits-1:0]   b;
      logic [CountBits-1:0] n;
   } acc_type;

   logic [CB-1:0]   cx_mem [MAX_ZONES];
   logic [CB-1:0]   cy_mem [MAX_ZONES];
   acc_type         acc_mem [MAX_ZONES];
   logic [MAX_ZONES-1:0] cvalid_ff;

   state_type      state_ff;
   logic [ZB:0]    z_ff;
   logic [ZB:0]    n_ff;
   req_type        cur_ff;
   acc_type        acc_rd_ff;
   logic [CB-1:0]  cx_rd_ff, cy_rd_ff;
   logic           cv_ff;
   logic [7:0]     ar_ff, ag_ff, ab_ff;
   rsp_type        out_ff;
   logic           out_valid_ff;
   logic           emit;
   logic           div_start;
   logic [SumBits-1:0] div_a;
   logic           div_done;
   logic [7:0]     div_q;
   logic [CB-1:0]  px, py, cx, cy;
   logic [CB:0]    half;
   logic           hit;
   logic [6:0]     lim;
   logic [ZB-1:0]  zi;

   assign zi = z_ff[ZB-1:0];
   assign px = q_data.pos_x[CB-1:0];
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign lim = (active_zones > 7'(MAX_ZONES)) ? 7'(MAX_ZONES) : active_zones;

   always_comb begin
      half = (CB+1)'(window_size[5:1]);
      cx = cv_ff ? cx_rd_ff : '0;
      cy = cv_ff ? cy_rd_ff : '0;
      hit = ({1'b0, cur_ff.pos_x[CB-1:0]} + half >= {1'b0, cx})
         && ({1'b0, cur_ff.pos_x[CB-1:0]} < {1'b0, cx} + half)
         && ({1'b0, cur_ff.pos_y[CB-1:0]} + half >= {1'b0, cy})
         && ({1'b0, cur_ff.pos_y[CB-1:0]} < {1'b0, cy} + half)
         && (acc_rd_ff.n < CountMax);
      py = q_data.pos_y[CB-1:0];
      div_start = 1'b0;
      div_a = acc_rd_ff.r;
      // red starts once the zone's sums are registered, green and blue chain on done
      case (state_ff)
         ST_WAIT:   div_start = 1'b1;
         ST_DIV_R:  begin div_start = div_done; div_a = acc_rd_ff.g; end
         ST_DIV_G:  begin div_start = div_done; div_a = acc_rd_ff.b; end
         default:   div_start = 1'b0;
      endcase
      pop = (state_ff == ST_IDLE) && q_valid;
      emit = (state_ff == ST_EMIT) && (!out_valid_ff || !rsp_stall);
   end

   zca_divider u_div (
      .clock, .reset, .start(div_start),
      .dividend(div_a),
      .divisor(acc_rd_ff.n), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         z_ff         <= '0;
         out_valid_ff <= 1'b0;
         cvalid_ff    <= '0;
      end else begin
         if (emit) out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               acc_mem[zi] <= '0;
               if (z_ff == (ZB+1)'(MAX_ZONES - 1)) begin
                  state_ff <= ST_IDLE;
                  z_ff <= '0;
               end else z_ff <= z_ff + 1'b1;
            end
            ST_IDLE: if (q_valid) begin
               cur_ff <= q_data;
               z_ff <= '0;
               case (q_data.command)
                  CMD_SET_ZONE: if ({1'b0, q_data.zone_index} < 7'(MAX_ZONES)) begin
                     cx_mem[q_data.zone_index[ZB-1:0]] <= px;
                     cy_mem[q_data.zone_index[ZB-1:0]] <= py;
                     cvalid_ff[q_data.zone_index[ZB-1:0]] <= 1'b1;
                  end
                  CMD_PIXEL: state_ff <= ST_PIX_RD;
                  CMD_END: begin
                     n_ff <= (ZB+1)'(lim);
                     state_ff <= ST_END_RD;
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_PIX_RD: begin
               acc_rd_ff <= acc_mem[zi];
               cx_rd_ff  <= cx_mem[zi];
               cy_rd_ff  <= cy_mem[zi];
               cv_ff     <= cvalid_ff[zi];
               state_ff  <= ST_PIX_WR;
            end
            ST_PIX_WR: begin
               if (hit)
                  acc_mem[zi] <= '{r: acc_rd_ff.r + SumBits'(cur_ff.red),
                                   g: acc_rd_ff.g + SumBits'(cur_ff.green),
                                   b: acc_rd_ff.b + SumBits'(cur_ff.blue),
                                   n: acc_rd_ff.n + 1'b1};
               if (z_ff == (ZB+1)'(MAX_ZONES - 1)) state_ff <= ST_IDLE;
               else begin
                  z_ff <= z_ff + 1'b1;
                  state_ff <= ST_PIX_RD;
               end
            end
            ST_END_RD: begin
               if (z_ff >= (ZB+1)'(MAX_ZONES)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  acc_rd_ff <= acc_mem[zi];
                  acc_mem[zi] <= '0;
                  state_ff <= (z_ff < n_ff) ? ST_WAIT : ST_END_RD;
                  if (z_ff >= n_ff) z_ff <= z_ff + 1'b1;
               end
            end
            ST_WAIT: state_ff <= ST_DIV_R;
            ST_DIV_R: if (div_done) begin ar_ff <= div_q; state_ff <= ST_DIV_G; end
            ST_DIV_G: if (div_done) begin ag_ff <= div_q; state_ff <= ST_DIV_B; end
            ST_DIV_B: if (div_done) begin ab_ff <= div_q; state_ff <= ST_EMIT; end
            // payload loads only once the previous result has left
            ST_EMIT: if (emit) begin
               out_ff.zone_id   <= 6'(zi);
               out_ff.avg_red   <= (acc_rd_ff.n == '0) ? 8'd0 : ar_ff;
               out_ff.avg_green <= (acc_rd_ff.n == '0) ? 8'd0 : ag_ff;
               out_ff.avg_blue  <= (acc_rd_ff.n == '0) ? 8'd0 : ab_ff;
               out_ff.last      <= (z_ff + 1'b1 == n_ff);
               z_ff <= z_ff + 1'b1;
               state_ff <= ST_END_RD;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== design/zone_color_averager.sv =====
// Per-zone box average of a streamed frame. Set-zone items load zone centres,
// pixel items add their color to every zone whose window holds them, and an
// end-of-frame item emits one result per active zone in zone order, last set
// on the final one, then clears the sums. Items enter a four-deep queue; the
// execution side walks the zone table one zone at a time, with a read and a
// write state per zone for a pixel. At end of frame each active zone takes
// three serial 20-step divisions, each remaining zone is only cleared, and a
// held result stalls the sweep. After reset a sweep over all MAX_ZONES zones
// clears the sums before any item is executed.
module zone_color_averager #(
   parameter int MAX_ZONES  = zca_pkg::MaxZonesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  zca_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output zca_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [6:0]       csr_data
);
   import zca_pkg::*;

   logic [5:0] window_ff;
   logic [6:0] active_ff;
   logic       q_valid, pop;
   req_type    q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WindowReset;
         active_ff <= ActiveReset;
      end else if (csr_valid) begin
         if (csr_index == CSR_WINDOW) window_ff <= csr_data[5:0];
         else active_ff <= csr_data;
      end
   end

   zca_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .pop, .q_valid, .q_data
   );

   zca_back #(.MAX_ZONES(MAX_ZONES)) u_back (
      .clock, .reset, .q_valid, .q_data, .pop,
      .window_size(window_ff), .active_zones(active_ff),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== design/zca_checker.sv =====
`include "zone_color_averager_macros.svh"
module zca_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input zca_pkg::rsp_type rsp_data
);
   `ZCA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ZCA_ASSERT_NEXT(a_order, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last,
      !rsp_valid || rsp_data.zone_id == $past(rsp_data.zone_id) + 6'd1)
   `ZCA_ASSERT_NEXT(a_rst, clock, 1'b0, reset, !rsp_valid)
   `ZCA_ASSERT_NOW(a_known, clock, reset, rsp_valid, !$isunknown(rsp_data))
endmodule

bind zone_color_averager zca_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);
